### rtl/rgb_integrate_and_fire_spiker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integrate-and-fire spiker unit
// Clocked implication checks, held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef RGB_INTEGRATE_AND_FIRE_SPIKER_UNIT_ASSERT_SVH
`define RGB_INTEGRATE_AND_FIRE_SPIKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBIF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbif assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBIF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbif assertion failed");

`endif

### rtl/rgbif_pkg.sv
// ----------------------------------------------------------------------------
// rgbif_pkg
// Shared types and constants of the integrate-and-fire spiker unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbif_pkg;

    // Default sizes, overridable at the top level.
    localparam int NUM_CELLS_DEF  = 4096;
    localparam int LEVEL_BITS_DEF = 32;

    // Fixed field widths.
    localparam int CELL_W   = 12;
    localparam int SAMPLE_W = 8;
    localparam int WEIGHT_W = 8;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    localparam int THRESH_W = 31;
    localparam int NUM_CH   = 3;

    // Request codes.
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_FIRE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FIRE_THRESHOLD = 1'b0;
    localparam logic CFG_KEEP_RESIDUAL  = 1'b1;

    // Configuration reset values.
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(1024);
    localparam logic                KEEP_RST   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // write zero to the entry under the sweep counter
        logic capture;  // take an input beat and read its cell
        logic exec;     // update the cell and load a fire result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // sweep counter at the last entry
        logic req_fire;    // the captured beat is a fire query
        logic out_block;   // result register full and not being drained
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/rgb_integrate_and_fire_spiker_unit.sv
// Sequence: a beat is captured and its cell read in the idle state, then the
// exec state updates the cell and loads a fire beat's result into the output
// register; an accumulate beat gives no result. A new beat is taken only once
// the read-then-write of the cell level memories is done; a stalled result
// holds the next fire beat. Reset: synchronous, active low; a clearing sweep
// then zeroes every level with input held off (configuration writes still land).
// ----------------------------------------------------------------------------
// rgb_integrate_and_fire_spiker_unit
// Per-cell integrate-and-fire spike encoder for RGB pixel streams.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_integrate_and_fire_spiker_unit
    import rgbif_pkg::*;
#(
    parameter int NUM_CELLS  = NUM_CELLS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input beats.
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic                i_req_type,
    input  wire logic [CELL_W-1:0]   i_cell_index,
    input  wire logic [SAMPLE_W-1:0] i_red_sample,
    input  wire logic [SAMPLE_W-1:0] i_green_sample,
    input  wire logic [SAMPLE_W-1:0] i_blue_sample,
    input  wire logic [WEIGHT_W-1:0] i_bin_weight,
    // Configuration writes.
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [THRESH_W-1:0] i_cfg_data,
    // Result beats.
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_spike_red,
    output logic                     o_spike_green,
    output logic                     o_spike_blue,
    output logic [CELL_W-1:0]        o_fired_cell
);

    // The controller sequences the sweep and each beat; the datapath holds
    // the three level memories and does all of the arithmetic.
    t_dp_cmd    cmd;
    t_dp_status status;

    rgbif_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // An accumulate beat adds weight times sample to each color level with
    // saturation. A fire beat compares each level with the threshold, emits
    // a spike where the level is strictly above it, and then subtracts the
    // threshold from each spiking level or clears it. Cells past the end of the
    // memory are left alone and answer a fire beat with no spikes.
    rgbif_dp #(
        .NUM_CELLS  (NUM_CELLS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req_type),
        .i_cell_index   (i_cell_index),
        .i_red_sample   (i_red_sample),
        .i_green_sample (i_green_sample),
        .i_blue_sample  (i_blue_sample),
        .i_bin_weight   (i_bin_weight),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_spike_red    (o_spike_red),
        .o_spike_green  (o_spike_green),
        .o_spike_blue   (o_spike_blue),
        .o_fired_cell   (o_fired_cell)
    );

endmodule

`default_nettype wire

### rtl/rgbif_dp.sv
// ----------------------------------------------------------------------------
// rgbif_dp
// Datapath: cell level memories, multiply, saturating add, threshold fire,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbif_dp
    import rgbif_pkg::*;
#(
    parameter int NUM_CELLS  = NUM_CELLS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    input  wire logic                i_req_type,
    input  wire logic [CELL_W-1:0]   i_cell_index,
    input  wire logic [SAMPLE_W-1:0] i_red_sample,
    input  wire logic [SAMPLE_W-1:0] i_green_sample,
    input  wire logic [SAMPLE_W-1:0] i_blue_sample,
    input  wire logic [WEIGHT_W-1:0] i_bin_weight,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [THRESH_W-1:0] i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_spike_red,
    output logic                     o_spike_green,
    output logic                     o_spike_blue,
    output logic [CELL_W-1:0]        o_fired_cell
);

    localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int IDX_W  = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;
    localparam int CMP_W  = (LEVEL_BITS > THRESH_W) ? LEVEL_BITS : THRESH_W;
    localparam int HIT_W  = 17;

    logic [THRESH_W-1:0] r_thresh;
    logic                r_keep;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_req;
    logic                r_hit;
    logic [ADDR_W-1:0]   r_addr;
    logic [CELL_W-1:0]   r_cell;
    logic                r_out_valid;
    logic [NUM_CH-1:0]   r_spike;
    logic [CELL_W-1:0]   r_fired_cell;

    logic [IDX_W-1:0]    cell_ext;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_hit;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic [NUM_CH-1:0]   spike;
    logic [SAMPLE_W-1:0] sample [NUM_CH];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_keep   <= KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRE_THRESHOLD: r_thresh <= i_cfg_data;
                CFG_KEEP_RESIDUAL:  r_keep   <= i_cfg_data[0];
                default:            r_keep   <= r_keep;
            endcase
        end
    end

    assign cell_ext = IDX_W'(i_cell_index);
    assign in_addr  = cell_ext[ADDR_W-1:0];
    assign in_hit   = HIT_W'(i_cell_index) < HIT_W'(NUM_CELLS);
    assign wr_addr  = i_cmd.clear ? r_clr_addr : r_addr;
    assign wr_en    = i_cmd.clear || (i_cmd.exec && r_hit);

    assign sample[0] = i_red_sample;
    assign sample[1] = i_green_sample;
    assign sample[2] = i_blue_sample;

    // Clearing sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_hit  <= in_hit;
            r_addr <= in_addr;
            r_cell <= i_cell_index;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [LEVEL_BITS-1:0] mem [NUM_CELLS];
        logic [LEVEL_BITS-1:0] r_rd;
        logic [PROD_W-1:0]     r_prod;
        logic [LEVEL_BITS:0]   sum;
        logic [LEVEL_BITS-1:0] acc_val;
        logic [CMP_W-1:0]      lvl_ext;
        logic [CMP_W-1:0]      thr_ext;
        logic [CMP_W-1:0]      diff;
        logic [LEVEL_BITS-1:0] fire_val;
        logic [LEVEL_BITS-1:0] wr_data;

        // Saturating accumulate.
        assign sum     = (LEVEL_BITS + 1)'(r_rd) + (LEVEL_BITS + 1)'(r_prod);
        assign acc_val = sum[LEVEL_BITS] ? '1 : sum[LEVEL_BITS-1:0];

        // Threshold compare and reset-by-subtraction or reset-to-zero.
        assign lvl_ext  = CMP_W'(r_rd);
        assign thr_ext  = CMP_W'(r_thresh);
        assign diff     = lvl_ext - thr_ext;
        assign spike[c] = lvl_ext > thr_ext;
        assign fire_val = !spike[c] ? r_rd : (r_keep ? diff[LEVEL_BITS-1:0] : '0);

        assign wr_data = i_cmd.clear ? '0 : ((r_req == REQ_FIRE) ? fire_val : acc_val);

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            if (i_cmd.capture) begin
                r_rd   <= mem[in_addr];
                r_prod <= PROD_W'(sample[c]) * PROD_W'(i_bin_weight);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && r_req == REQ_FIRE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_req == REQ_FIRE) begin
            r_spike      <= r_hit ? spike : '0;
            r_fired_cell <= r_cell;
        end
    end

    assign o_status.clear_last = r_clr_addr == ADDR_W'(NUM_CELLS - 1);
    assign o_status.req_fire   = r_req == REQ_FIRE;
    assign o_status.out_block  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_spike_red   = r_spike[0];
    assign o_spike_green = r_spike[1];
    assign o_spike_blue  = r_spike[2];
    assign o_fired_cell  = r_fired_cell;

endmodule

`default_nettype wire

### rtl/rgbif_ctrl.sv
// ----------------------------------------------------------------------------
// rgbif_ctrl
// Controller: clearing sweep after reset, then capture and execute of
// one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_integrate_and_fire_spiker_unit_assert.svh"

module rgbif_ctrl
    import rgbif_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // A fire result waits until the result register is free.
                if (!(i_status.req_fire && i_status.out_block)) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_ready = r_state == S_IDLE;

    `RGBIF_ASSERT_NXT(a_capture_then_exec, o_cmd.capture, r_state == S_EXEC)
    `RGBIF_ASSERT_IMP(a_no_result_overwrite,
        r_state == S_EXEC && i_status.req_fire && i_status.out_block, !o_cmd.exec)
    `RGBIF_ASSERT_IMP(a_clear_exclusive, o_cmd.clear, !o_ready && !o_cmd.exec)
    `RGBIF_ASSERT_NXT(a_exec_then_ready, o_cmd.exec, o_ready)

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rgb_integrate_and_fire_spiker_unit
// Drives pixel beats (accumulate and fire queries) with random idle gaps on
// both handshakes. A local copy of the cell levels predicts every fire result,
// and each result beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rgbif_pkg::*;

    localparam int    LEVEL_W    = LEVEL_BITS_DEF;
    localparam int    CELLS      = NUM_CELLS_DEF;
    localparam int    HALF_CLK   = 6;
    // A legal run is the clearing sweep, then about 650 beats; even with the
    // longest gaps and stalls the slowest run stays far inside the timeout.
    localparam int    TIMEOUT_NS = 10_000_000;
    // Cycles allowed for an accumulate beat to finish its read-modify-write
    // after the last result has arrived.
    localparam int    SETTLE_CYC = 4;
    localparam int    BURST_BEATS = 40;
    localparam logic [THRESH_W-1:0] BURST_THRESH = THRESH_W'(1_000_000);
    localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};

    // Expected content of one result beat.
    typedef struct {
        logic              spike_red;
        logic              spike_green;
        logic              spike_blue;
        logic [CELL_W-1:0] fired_cell;
    } t_spike_result;

    // ------------------------------------------------------------------------
    // DUT connections. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                px_valid       = 1'b0;
    logic                px_ready;
    logic                px_req_type    = REQ_ACCUM;
    logic [CELL_W-1:0]   px_cell_index  = '0;
    logic [SAMPLE_W-1:0] px_red         = '0;
    logic [SAMPLE_W-1:0] px_green       = '0;
    logic [SAMPLE_W-1:0] px_blue        = '0;
    logic [WEIGHT_W-1:0] px_weight      = '0;
    logic                cfg_we         = 1'b0;
    logic                cfg_index      = CFG_FIRE_THRESHOLD;
    logic [THRESH_W-1:0] cfg_data       = '0;
    logic                spk_valid;
    logic                spk_ready      = 1'b0;
    logic                spk_red;
    logic                spk_green;
    logic                spk_blue;
    logic [CELL_W-1:0]   spk_cell;

    rgb_integrate_and_fire_spiker_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (px_valid),
        .o_ready        (px_ready),
        .i_req_type     (px_req_type),
        .i_cell_index   (px_cell_index),
        .i_red_sample   (px_red),
        .i_green_sample (px_green),
        .i_blue_sample  (px_blue),
        .i_bin_weight   (px_weight),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_valid        (spk_valid),
        .i_ready        (spk_ready),
        .o_spike_red    (spk_red),
        .o_spike_green  (spk_green),
        .o_spike_blue   (spk_blue),
        .o_fired_cell   (spk_cell)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the three level memories and of the
    // two configuration registers.
    // ------------------------------------------------------------------------
    logic [LEVEL_W-1:0]  level_mem [NUM_CH][CELLS];
    logic [THRESH_W-1:0] thresh_copy = THRESH_RST;
    logic                keep_copy   = KEEP_RST;

    t_spike_result pending_spikes [$];
    int            err_count = 0;
    // When set, both sides run back to back with no idle cycles.
    bit            no_idle   = 1'b0;

    initial begin
        forever #(HALF_CLK) i_clk = ~i_clk;
    end

    // A fixed time limit catches a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("rgb_integrate_and_fire_spiker_unit: mismatch");
        $finish;
    end

    // Adds weight times sample to one level, holding it at the maximum.
    function automatic logic [LEVEL_W-1:0] saturate_add(input logic [LEVEL_W-1:0] level,
                                                        input logic [SAMPLE_W-1:0] sample,
                                                        input logic [WEIGHT_W-1:0] weight);
        logic [PROD_W-1:0]  prod;
        logic [LEVEL_W:0]   sum;
        prod = PROD_W'(sample) * PROD_W'(weight);
        sum  = {1'b0, level} + (LEVEL_W+1)'(prod);
        return sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
    endfunction

    // Applies one accepted beat to the level copy. A fire query returns its
    // spikes through the expected-result queue.
    task automatic integrate_or_fire(input logic req, input logic [CELL_W-1:0] cell_idx,
                                     input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                                     input logic [SAMPLE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        logic [SAMPLE_W-1:0] smp [NUM_CH];
        logic                fired [NUM_CH];
        t_spike_result       res;
        smp[0] = r;
        smp[1] = g;
        smp[2] = b;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            fired[ch] = 1'b0;
            if (req == REQ_ACCUM) begin
                level_mem[ch][cell_idx] = saturate_add(level_mem[ch][cell_idx], smp[ch], w);
            end else if (level_mem[ch][cell_idx] > LEVEL_W'(thresh_copy)) begin
                fired[ch] = 1'b1;
                // Keep-residual mode leaves whatever lies above the threshold.
                level_mem[ch][cell_idx] = keep_copy
                    ? level_mem[ch][cell_idx] - LEVEL_W'(thresh_copy) : '0;
            end
        end
        if (req == REQ_FIRE) begin
            res.spike_red   = fired[0];
            res.spike_green = fired[1];
            res.spike_blue  = fired[2];
            res.fired_cell  = cell_idx;
            pending_spikes.push_back(res);
        end
    endtask

    // Sends one pixel beat after a random idle gap and predicts its effect at
    // the edge where it is accepted. Valid stays high across back-to-back
    // beats, so it is never lowered and raised in the same time step.
    task automatic send_pixel_beat(input logic req, input logic [CELL_W-1:0] cell_idx,
                                   input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                                   input logic [SAMPLE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            px_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        px_valid      <= 1'b1;
        px_req_type   <= req;
        px_cell_index <= cell_idx;
        px_red        <= r;
        px_green      <= g;
        px_blue       <= b;
        px_weight     <= w;
        do @(posedge i_clk); while (!px_ready);
        integrate_or_fire(req, cell_idx, r, g, b, w);
    endtask

    // Holds off input until every expected result has come back, then lets
    // the last accumulate beat finish its write.
    task automatic settle_block();
        @(negedge i_clk);
        px_valid <= 1'b0;
        while (pending_spikes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register writes are issued only while the block is idle.
    task automatic write_reg(input logic idx, input logic [THRESH_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FIRE_THRESHOLD) begin
            thresh_copy = data;
        end else begin
            keep_copy = data[0];
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: a random stall before each beat, then ready stays high
    // until the beat is taken and checked against the oldest prediction.
    // ------------------------------------------------------------------------
    initial begin
        int            stall;
        t_spike_result exp_res;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (stall > 0) begin
                spk_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            spk_ready <= 1'b1;
            do @(posedge i_clk); while (!spk_valid);
            if (pending_spikes.size() == 0) begin
                $error("unexpected result beat for cell %0d", spk_cell);
                err_count++;
            end else begin
                exp_res = pending_spikes.pop_front();
                if (spk_red !== exp_res.spike_red) begin
                    $error("spike_red: expected %0d, actual %0d", exp_res.spike_red, spk_red);
                    err_count++;
                end
                if (spk_green !== exp_res.spike_green) begin
                    $error("spike_green: expected %0d, actual %0d",
                           exp_res.spike_green, spk_green);
                    err_count++;
                end
                if (spk_blue !== exp_res.spike_blue) begin
                    $error("spike_blue: expected %0d, actual %0d",
                           exp_res.spike_blue, spk_blue);
                    err_count++;
                end
                if (spk_cell !== exp_res.fired_cell) begin
                    $error("fired_cell: expected %0d, actual %0d",
                           exp_res.fired_cell, spk_cell);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------------

    // Default registers straight out of reset: the threshold is 1024 and the
    // residual is kept. Covers weight zero and both ends of the cell range.
    task automatic test_reset_defaults();
        send_pixel_beat(REQ_ACCUM, 12'd0, 8'd255, 8'd4, 8'd0, 8'd255);
        send_pixel_beat(REQ_ACCUM, 12'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel_beat(REQ_FIRE, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel_beat(REQ_FIRE, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel_beat(REQ_ACCUM, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel_beat(REQ_FIRE, 12'd4095, 8'd170, 8'd85, 8'd170, 8'd85);
        send_pixel_beat(REQ_FIRE, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();
    endtask

    // Clear mode with a threshold of one: a level of exactly one
    // does not fire, two does and is wiped.
    task automatic test_clear_mode();
        write_reg(CFG_KEEP_RESIDUAL, THRESH_W'(0));
        write_reg(CFG_FIRE_THRESHOLD, THRESH_W'(1));
        send_pixel_beat(REQ_ACCUM, 12'd2730, 8'd1, 8'd2, 8'd0, 8'd1);
        send_pixel_beat(REQ_FIRE, 12'd2730, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel_beat(REQ_FIRE, 12'd2730, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel_beat(REQ_ACCUM, 12'd2730, 8'd0, 8'd0, 8'd3, 8'd1);
        send_pixel_beat(REQ_FIRE, 12'd2730, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();
    endtask

    // A zero threshold fires on any nonzero level; keeping the residual then
    // leaves the level untouched, so the same cell fires again.
    task automatic test_zero_threshold();
        write_reg(CFG_FIRE_THRESHOLD, THRESH_W'(0));
        write_reg(CFG_KEEP_RESIDUAL, THRESH_W'(1));
        send_pixel_beat(REQ_ACCUM, 12'd1365, 8'd1, 8'd0, 8'd9, 8'd1);
        send_pixel_beat(REQ_FIRE, 12'd1365, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel_beat(REQ_FIRE, 12'd1365, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();
        write_reg(CFG_KEEP_RESIDUAL, THRESH_W'(0));
        send_pixel_beat(REQ_FIRE, 12'd1365, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel_beat(REQ_FIRE, 12'd1365, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();
    endtask

    // Builds one cell up to a large level with the biggest products, then
    // fires it repeatedly under a large threshold so that the residual steps
    // down until it no longer exceeds the threshold. Runs without idling to
    // keep the burst short.
    task automatic test_large_level();
        no_idle = 1'b1;
        write_reg(CFG_KEEP_RESIDUAL, THRESH_W'(1));
        write_reg(CFG_FIRE_THRESHOLD, BURST_THRESH);
        for (int n = 0; n < BURST_BEATS; n++) begin
            send_pixel_beat(REQ_ACCUM, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255);
        end
        repeat (3) send_pixel_beat(REQ_FIRE, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();
        no_idle = 1'b0;
    endtask

    // Random phases, each under its own register setting. Most beats hit a
    // few hot cells so that levels build up and cross the threshold; the
    // rest go anywhere. Midway through each phase the sender waits for all results.
    task automatic test_random_phases();
        logic [CELL_W-1:0]   hot_cell [4];
        logic [CELL_W-1:0]   cell_idx;
        logic                req;
        logic [THRESH_W-1:0] thr;
        int                  pick;
        for (int phase = 0; phase < 6; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                thr = THRESH_W'(1);
            end else if (pick == 1) begin
                thr = THRESH_MAX;
            end else if (pick < 6) begin
                thr = THRESH_W'($urandom_range(1, 5000));
            end else begin
                thr = THRESH_W'($urandom_range(5000, 300000));
            end
            write_reg(CFG_FIRE_THRESHOLD, thr);
            write_reg(CFG_KEEP_RESIDUAL, THRESH_W'($urandom_range(0, 1)));
            for (int k = 0; k < 4; k++) begin
                hot_cell[k] = CELL_W'($urandom_range(0, CELLS - 1));
            end
            for (int n = 0; n < 100; n++) begin
                req      = ($urandom_range(0, 3) == 0) ? REQ_FIRE : REQ_ACCUM;
                cell_idx = ($urandom_range(0, 4) == 0) ? CELL_W'($urandom_range(0, CELLS - 1))
                                                       : hot_cell[$urandom_range(0, 3)];
                send_pixel_beat(req, cell_idx, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                SAMPLE_W'($urandom), WEIGHT_W'($urandom));
                if (n == 50) begin
                    settle_block();
                end
            end
            settle_block();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. The block clears its level memories after reset while
    // holding ready low; the first beat simply waits for that.
    // ------------------------------------------------------------------------
    initial begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int c = 0; c < CELLS; c++) begin
                level_mem[ch][c] = '0;
            end
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_clear_mode();
        test_zero_threshold();
        test_large_level();
        test_random_phases();

        settle_block();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("rgb_integrate_and_fire_spiker_unit: match");
        end else begin
            $display("rgb_integrate_and_fire_spiker_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### rgb_integrate_and_fire_spiker_unit.f
+incdir+rtl
rtl/rgbif_pkg.sv
rtl/rgbif_dp.sv
rtl/rgbif_ctrl.sv
rtl/rgb_integrate_and_fire_spiker_unit.sv
tb/sv/tb.sv
